// ===== design/rmtf_pkg.sv =====
// Shared types and constants for the move-to-front recent entry list.
// Used by the storage cells, the top level and the port checker.
`default_nettype none
package rmtf_pkg;

  // Number of cells in the chain, and the widths that follow from it
  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Compare domain wide enough for the count plus one and the 6-bit limit
  localparam int CMP_W = (CNT_W + 1 > 6) ? CNT_W + 1 : 6;

  // Operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [5:0] MAX_ENTRIES_RST = 6'd20;

  typedef struct packed {
    logic [7:0]  drv;
    logic [7:0]  spc;
    logic [11:0] chn;
    logic [15:0] svc;
    logic [15:0] net;
  } entry_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  driver_id;
    logic [7:0]  space;
    logic [11:0] channel_number;
    logic [15:0] service_id;
    logic [15:0] network_id;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [7:0]  out_driver_id;
    logic [7:0]  out_space;
    logic [11:0] out_channel_number;
    logic [15:0] out_service_id;
    logic [15:0] out_network_id;
    logic [5:0]  entry_count;
    logic        add_unchanged;
  } out_item_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;   // capture the key compare
    logic in_use;   // cell position lies below the held count
    logic shift_en; // take the neighbour's entry
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/rmtf_cell.sv =====
// One storage cell of the list: holds an entry, compares it with the search
// key and takes its upstream neighbour's entry on a shift. Uses rmtf_pkg.
`default_nettype none
module rmtf_cell (
  input  wire                 clk,
  input  rmtf_pkg::cell_ctl_t ctl,
  input  rmtf_pkg::entry_t    key,
  input  rmtf_pkg::entry_t    prev,
  output rmtf_pkg::entry_t    q,
  output logic                match
);
  import rmtf_pkg::*;

  entry_t entry_r;
  logic   match_r;
  logic   key_eq;

  // Compare on everything but the network id
  assign key_eq = (entry_r.drv == key.drv) && (entry_r.spc == key.spc) &&
                  (entry_r.chn == key.chn) && (entry_r.svc == key.svc);

  // Hold the compare result for the update cycle
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= ctl.in_use & key_eq;
    end
  end

  // Advance the entry down the chain
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      entry_r <= prev;
    end
  end

  assign q     = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

// ===== design/recent_entry_move_to_front_list_unit.sv =====
// Top level of the move-to-front recent entry list: sequencer, count,
// limit register and the chain of rmtf_cell instances. Uses rmtf_pkg.
// The result strobe follows the start transfer through the compare, update and output
// states; busy covers compare and update, so a new item may start in the output state.
// The sequence is set by the registered compare in every cell and the update pass.
// Reset: count cleared, limit set to 20; cell contents stay undefined.
// The receiver cannot stall: each result shows for one cycle only.
`default_nettype none
module recent_entry_move_to_front_list_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  rmtf_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output rmtf_pkg::out_item_t  out_result,
  input  wire                  cfg_wr_en,
  input  wire [5:0]            cfg_wr_data
);
  import rmtf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [5:0]       max_r;
  in_item_t         item_r;
  out_item_t        res_r, res_nxt;
  logic             strobe_r;

  entry_t           new_entry;
  entry_t           cell_q   [DEPTH];
  entry_t           cell_prev[DEPTH];
  cell_ctl_t        cell_ctl [DEPTH];
  logic [DEPTH-1:0] match_v;
  logic [DEPTH-1:0] before_v;
  logic [DEPTH-1:0] low_mask;

  logic             accept;
  logic             found;
  logic             unchanged;
  logic             do_move;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] cnt_after;
  logic             rd_valid;
  entry_t           rd_entry;

  assign accept = start && !busy;
  assign busy   = (state_r == ST_CMP) || (state_r == ST_UPD);

  assign new_entry = '{drv: item_r.driver_id, spc: item_r.space,
                       chn: item_r.channel_number, svc: item_r.service_id,
                       net: item_r.network_id};

  // Sequence one item through compare, update and output
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = accept ? ST_CMP : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Find the first matching cell: each cell learns whether any cell ahead matched
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      low_mask    = (DEPTH'(1) << i) - DEPTH'(1);
      before_v[i] = |(match_v & low_mask);
    end
  end

  assign found     = |match_v;
  assign unchanged = match_v[0] && (cell_q[0].net == item_r.network_id);
  assign do_move   = (state_r == ST_UPD) && (item_r.operation == OP_ADD) && !unchanged;

  // Drive the chain controls
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].cmp_en   = (state_r == ST_CMP);
      cell_ctl[i].in_use   = CNT_W'(i) < held_r;
      cell_ctl[i].shift_en = do_move && !before_v[i];
    end
  end

  // Chain of cells; the front cell takes the new entry
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign cell_prev[g] = new_entry;
    end else begin : g_body
      assign cell_prev[g] = cell_q[g-1];
    end
    rmtf_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[g]),
      .key   (new_entry),
      .prev  (cell_prev[g]),
      .q     (cell_q[g]),
      .match (match_v[g])
    );
  end

  // Work out the count after an add, dropping one from the back past the limit
  always_comb begin
    limit     = (CMP_W'(max_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(max_r);
    cnt_after = found ? CMP_W'(held_r) : CMP_W'(held_r) + CMP_W'(1);
    if (cnt_after > limit) begin
      cnt_after = cnt_after - CMP_W'(1);
    end
  end

  assign rd_valid = CMP_W'(item_r.read_index) < CMP_W'(held_r);
  assign rd_entry = cell_q[item_r.read_index[IDX_W-1:0]];

  // Build the next count and the result
  always_comb begin
    held_nxt = held_r;
    res_nxt  = '0;
    if (state_r == ST_UPD) begin
      case (item_r.operation)
        OP_ADD: begin
          if (unchanged) begin
            res_nxt.add_unchanged = 1'b1;
          end else begin
            held_nxt = cnt_after[CNT_W-1:0];
          end
        end
        OP_READ: begin
          if (rd_valid) begin
            res_nxt.entry_valid        = 1'b1;
            res_nxt.out_driver_id      = rd_entry.drv;
            res_nxt.out_space          = rd_entry.spc;
            res_nxt.out_channel_number = rd_entry.chn;
            res_nxt.out_service_id     = rd_entry.svc;
            res_nxt.out_network_id     = rd_entry.net;
          end
        end
        OP_CLEAR: held_nxt = '0;
        default:  held_nxt = held_r;
      endcase
      res_nxt.entry_count = 6'(held_nxt);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      max_r    <= MAX_ENTRIES_RST;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      strobe_r <= (state_r == ST_UPD);
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == ST_UPD) begin
      res_r <= res_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_result = res_r;

endmodule
`default_nettype wire

// ===== design/rmtf_checker.sv =====
// Port-level checks for the move-to-front recent entry list, bound to the
// top level. Uses rmtf_pkg.
`default_nettype none
module rmtf_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_strobe,
  input rmtf_pkg::out_item_t out_result
);
  import rmtf_pkg::*;

  // Every transfer in gives its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result strobe missing after transfer");

  // Results are single-cycle pulses
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // A read hit never reports an unchanged add
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.entry_valid) |-> !out_result.add_unchanged)
    else $error("read hit flagged as unchanged add");

  // The count never exceeds the chain length
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.entry_count <= 6'(DEPTH)))
    else $error("entry count above depth");

endmodule

bind recent_entry_move_to_front_list_unit rmtf_checker u_rmtf_checker (.*);
`default_nettype wire

// ===== tb/recent_entry_move_to_front_list_unit_tb.sv =====
// Self-checking testbench for the move-to-front recent entry list unit.
// Depends on rmtf_pkg for the item types, operation codes and list depth; drives a
// directed table, then random traffic under several limits, checked by a list predictor.
module recent_entry_move_to_front_list_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmtf_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         CHUNK_ITEMS    = 150;
  localparam int         POOL_SIZE      = 48;
  localparam int         SETTLE_CYCLES  = 6;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         PRINT_LIMIT    = 40;

  localparam entry_t ZERO_E     = '0;
  localparam entry_t ONES_E     = '1;
  localparam entry_t ZERO_NETF  = '{drv: 8'h00, spc: 8'h00, chn: 12'h000,
                                    svc: 16'h0000, net: 16'hffff};
  localparam entry_t ONES_NET0  = '{drv: 8'hff, spc: 8'hff, chn: 12'hfff,
                                    svc: 16'hffff, net: 16'h0000};
  localparam entry_t SAMPLE_E   = '{drv: 8'h12, spc: 8'h34, chn: 12'h567,
                                    svc: 16'h89ab, net: 16'hcdef};

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  in_item_t    in_item     = '0;
  logic        out_strobe;
  out_item_t   out_result;
  logic        cfg_wr_en   = 1'b0;
  logic [5:0]  cfg_wr_data = '0;

  // Predictor copy of the list, its count and the limit register
  entry_t      recent_list [DEPTH];
  int          recent_count = 0;
  int          recent_limit = MAX_ENTRIES_RST;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  entry_t      key_pool [POOL_SIZE];
  int          mismatch_count = 0;
  int          result_index   = 0;
  int          sender_gap_pct = 0;
  int          idle_cycles    = 0;

  recent_entry_move_to_front_list_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_strobe  (out_strobe),
    .out_result  (out_result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Apply one operation to the predicted list and return the result it gives
  function automatic out_item_t recent_list_apply(in_item_t it);
    out_item_t res;
    entry_t    nw;
    int        hit;
    int        top;
    int        cap;
    int        i;
    res = '0;
    nw  = '{drv: it.driver_id, spc: it.space, chn: it.channel_number,
            svc: it.service_id, net: it.network_id};
    hit = -1;
    case (it.operation)
      OP_ADD: begin
        for (i = 0; i < recent_count; i++) begin
          if (hit < 0 && recent_list[i].drv == nw.drv && recent_list[i].spc == nw.spc &&
              recent_list[i].chn == nw.chn && recent_list[i].svc == nw.svc)
            hit = i;
        end
        if (hit == 0 && recent_list[0].net == nw.net) begin
          res.add_unchanged = 1'b1;
        end else begin
          // Pull the match out, or open a slot at the back, then insert at the front
          if (hit >= 0) begin
            top = hit;
          end else begin
            top = (recent_count < DEPTH) ? recent_count : DEPTH - 1;
            recent_count++;
          end
          for (i = top; i > 0; i--)
            recent_list[i] = recent_list[i - 1];
          recent_list[0] = nw;
          // Drop at most one entry from the back
          cap = (recent_limit > DEPTH) ? DEPTH : recent_limit;
          if (recent_count > cap)
            recent_count--;
          if (recent_count > DEPTH)
            recent_count = DEPTH;
        end
      end
      OP_READ: begin
        if (it.read_index < recent_count) begin
          res.entry_valid        = 1'b1;
          res.out_driver_id      = recent_list[it.read_index].drv;
          res.out_space          = recent_list[it.read_index].spc;
          res.out_channel_number = recent_list[it.read_index].chn;
          res.out_service_id     = recent_list[it.read_index].svc;
          res.out_network_id     = recent_list[it.read_index].net;
        end
      end
      OP_CLEAR: recent_count = 0;
      default: ;
    endcase
    res.entry_count = recent_count[5:0];
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, entry_t e, logic [5:0] idx);
    in_item_t it;
    it.operation      = op;
    it.driver_id      = e.drv;
    it.space          = e.spc;
    it.channel_number = e.chn;
    it.service_id     = e.svc;
    it.network_id     = e.net;
    it.read_index     = idx;
    return it;
  endfunction

  function automatic out_item_t make_result(logic v, entry_t e, int cnt, logic u);
    out_item_t r;
    r.entry_valid        = v;
    r.out_driver_id      = e.drv;
    r.out_space          = e.spc;
    r.out_channel_number = e.chn;
    r.out_service_id     = e.svc;
    r.out_network_id     = e.net;
    r.entry_count        = cnt[5:0];
    r.add_unchanged      = u;
    return r;
  endfunction

  // Mostly adds from a small key pool so that matches, moves and full lists occur;
  // the rest reads, some of them near the count, with rare clears and unused codes
  function automatic in_item_t next_random_item();
    logic [95:0] raw;
    in_item_t    it;
    entry_t      e;
    int          roll;
    raw  = {$urandom, $urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    roll = $urandom_range(99);
    if (roll < 58) begin
      it.operation = OP_ADD;
      roll = $urandom_range(99);
      if (roll < 15 && recent_count > 0) begin
        e = recent_list[0];
      end else if (roll < 75) begin
        e = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll[0])
          e.net = it.network_id;
      end else begin
        e = '{drv: it.driver_id, spc: it.space, chn: it.channel_number,
              svc: it.service_id, net: it.network_id};
      end
      it.driver_id      = e.drv;
      it.space          = e.spc;
      it.channel_number = e.chn;
      it.service_id     = e.svc;
      it.network_id     = e.net;
    end else if (roll < 96) begin
      it.operation = OP_READ;
      if (roll[0])
        it.read_index = $urandom_range(recent_count + 1);
    end else if (roll < 98) begin
      it.operation = OP_CLEAR;
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t res);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Offer one item, wait for its transfer and record what it should produce.
  // Start is left high on return; the caller assigns it next in this step.
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t predicted;
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predicted = recent_list_apply(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Hold off until every result is in and the block has gone quiet, then write the limit
  task automatic drain_and_set_limit(logic [5:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    recent_limit  = value;
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch on result %0d: %s", $time, result_index, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_result));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("entry_valid",        out_result.entry_valid,        want.entry_valid);
        check_field("out_driver_id",      out_result.out_driver_id,      want.out_driver_id);
        check_field("out_space",          out_result.out_space,          want.out_space);
        check_field("out_channel_number", out_result.out_channel_number,
                    want.out_channel_number);
        check_field("out_service_id",     out_result.out_service_id,     want.out_service_id);
        check_field("out_network_id",     out_result.out_network_id,     want.out_network_id);
        check_field("entry_count",        out_result.entry_count,        want.entry_count);
        check_field("add_unchanged",      out_result.add_unchanged,      want.add_unchanged);
      end
      result_index++;
    end
  end

  // Abort when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : run
    int     chunk_limits [6];
    int     chunk_gaps   [6];
    entry_t v;
    int     k;

    chunk_limits = '{32, 2, 63, 0, 1, 17};
    chunk_gaps   = '{7, 7, 81, 81, 0, 0};

    foreach (key_pool[k])
      key_pool[k] = {$urandom, $urandom};

    // Directed table under the reset limit: empty list, extremes, moves, key differences
    add_row(make_item(OP_READ, ZERO_E, 6'd0), 1, make_result(0, ZERO_E, 0, 0));
    add_row(make_item(OP_READ, ZERO_E, 6'd63), 1, make_result(0, ZERO_E, 0, 0));
    add_row(make_item(OP_UNUSED, ONES_E, 6'd63), 1, make_result(0, ZERO_E, 0, 0));
    add_row(make_item(OP_CLEAR, ZERO_E, 6'd0), 1, make_result(0, ZERO_E, 0, 0));
    add_row(make_item(OP_ADD, ZERO_E, 6'd0), 1, make_result(0, ZERO_E, 1, 0));
    add_row(make_item(OP_ADD, ZERO_E, 6'd0), 1, make_result(0, ZERO_E, 1, 1));
    add_row(make_item(OP_ADD, ONES_E, 6'd0), 1, make_result(0, ZERO_E, 2, 0));
    add_row(make_item(OP_READ, ZERO_E, 6'd0), 1, make_result(1, ONES_E, 2, 0));
    add_row(make_item(OP_READ, ZERO_E, 6'd1), 1, make_result(1, ZERO_E, 2, 0));
    add_row(make_item(OP_READ, ZERO_E, 6'd2), 1, make_result(0, ZERO_E, 2, 0));
    add_row(make_item(OP_ADD, ZERO_NETF, 6'd0), 0, '0);
    add_row(make_item(OP_ADD, ONES_E, 6'd0), 0, '0);
    add_row(make_item(OP_ADD, ONES_E, 6'd0), 0, '0);
    add_row(make_item(OP_ADD, ONES_NET0, 6'd0), 0, '0);
    add_row(make_item(OP_READ, ZERO_E, 6'd0), 0, '0);
    add_row(make_item(OP_READ, ZERO_E, 6'd1), 0, '0);
    add_row(make_item(OP_UNUSED, SAMPLE_E, 6'd1), 0, '0);
    add_row(make_item(OP_CLEAR, ONES_E, 6'd63), 1, make_result(0, ZERO_E, 0, 0));
    add_row(make_item(OP_READ, ZERO_E, 6'd0), 1, make_result(0, ZERO_E, 0, 0));
    add_row(make_item(OP_ADD, SAMPLE_E, 6'd0), 1, make_result(0, ZERO_E, 1, 0));
    v = SAMPLE_E; v.drv = ~v.drv;
    add_row(make_item(OP_ADD, v, 6'd0), 0, '0);
    v = SAMPLE_E; v.spc = ~v.spc;
    add_row(make_item(OP_ADD, v, 6'd0), 0, '0);
    v = SAMPLE_E; v.chn = ~v.chn;
    add_row(make_item(OP_ADD, v, 6'd0), 0, '0);
    v = SAMPLE_E; v.svc = ~v.svc;
    add_row(make_item(OP_ADD, v, 6'd0), 0, '0);
    add_row(make_item(OP_READ, ZERO_E, 6'd4), 0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    sender_gap_pct = 7;
    foreach (dir_rows[k])
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

    // Random traffic, one limit setting and one sender gap setting per chunk
    for (k = 0; k < 6; k++) begin
      drain_and_set_limit(chunk_limits[k][5:0]);
      sender_gap_pct = chunk_gaps[k];
      repeat (CHUNK_ITEMS) send_item(next_random_item(), 0, '0);
    end

    // Drain the last results, then allow for stray strobes
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
